>>> rtl/core/packed_trie_lookup_defines.svh
// ----------------------------------------------------------------------------
// Packed trie lookup: assertion macros
// Shared property macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_TRIE_LOOKUP_DEFINES_SVH
`define PACKED_TRIE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PTL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packed_trie_lookup: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packed_trie_lookup: next-cycle check failed");
`else
`define PTL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: package
// Sizes, status codes and the control/status structs shared by the modules.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned CHAR_BITS   = 16;

  localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned SYM_W   = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned ENTRY_W = SYM_W + 1 + IDX_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  // only the low CHAR_BITS bits of a character take part
  localparam logic [SYM_W-1:0]  CHAR_MASK = SYM_W'((64'd1 << CHAR_BITS) - 64'd1);

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic load;    // write a table entry
    logic start;   // take a char word and begin the sibling scan
    logic ignore;  // take a char word while missed
    logic step;    // move to the next sibling
    logic resolve; // close the scan and latch the result
    logic emit;    // move the latched result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_char;
    logic missed;
    logic scan_more;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/ptl_ram.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: controller
// Sequences load, scan and result hand-off for each input word.
// ----------------------------------------------------------------------------
module ptl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ptl_pkg::dp_status_t   dp_status_i,
  output ptl_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!dp_status_i.is_char) begin
            cmd_o.load = 1'b1;
          end else if (dp_status_i.missed) begin
            cmd_o.ignore = 1'b1;
            state_d      = S_EMIT;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (dp_status_i.scan_more) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.resolve = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (dp_status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/ptl_dp.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: datapath
// Trie table, walk position, miss flag and the output register.
// ----------------------------------------------------------------------------
module ptl_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ptl_pkg::ctrl_cmd_t        cmd_i,
  output ptl_pkg::dp_status_t       dp_status_o,
  input  logic                      kind_i,
  input  logic [11:0]               entry_addr_i,
  input  logic [15:0]               entry_symbol_i,
  input  logic                      entry_more_i,
  input  logic [15:0]               entry_index_i,
  input  logic [15:0]               char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [15:0]               result_index_o
);

  function automatic logic [ptl_pkg::SYM_W-1:0] fold_upper(
    input logic [ptl_pkg::SYM_W-1:0] c
  );
    logic [ptl_pkg::SYM_W-1:0] r;
    r = c;
    if (c >= ptl_pkg::SYM_W'(8'h61) && c <= ptl_pkg::SYM_W'(8'h7A)) begin
      r = c - ptl_pkg::SYM_W'(8'h20);
    end
    return r;
  endfunction

  logic [ptl_pkg::SYM_W-1:0]   in_c;
  logic [ptl_pkg::SYM_W-1:0]   c_q;
  logic [ptl_pkg::ADDR_W-1:0]  pos_q;
  logic [ptl_pkg::ADDR_W-1:0]  cur_q, cur_d;
  logic                        missed_q, missed_d;
  logic [1:0]                  res_status_q, res_status_d;
  logic [ptl_pkg::IDX_W-1:0]   res_index_q, res_index_d;
  logic                        out_valid_q;
  logic [1:0]                  out_status_q;
  logic [ptl_pkg::IDX_W-1:0]   out_index_q;

  logic [31:0]                 waddr_ext;
  logic                        wr_en;
  logic [ptl_pkg::ADDR_W-1:0]  raddr;
  logic [ptl_pkg::ENTRY_W-1:0] rdata;
  logic [ptl_pkg::SYM_W-1:0]   rd_sym;
  logic                        rd_more;
  logic [ptl_pkg::IDX_W-1:0]   rd_idx;
  logic                        advance;
  logic                        at_last;
  logic                        found;
  logic                        idx_in_range;

  assign in_c = fold_upper(char_code_i & ptl_pkg::CHAR_MASK);

  // table store; loads beyond the depth are dropped
  assign waddr_ext = 32'(entry_addr_i);
  assign wr_en     = cmd_i.load && (waddr_ext < 32'(ptl_pkg::TABLE_DEPTH));
  assign raddr     = cmd_i.step ? pos_q + ptl_pkg::ADDR_W'(1) : cur_q;

  ptl_ram #(
    .WIDTH (ptl_pkg::ENTRY_W),
    .DEPTH (ptl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ptl_pkg::ADDR_W'(waddr_ext)),
    .wdata_i ({entry_symbol_i, entry_more_i, entry_index_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign {rd_sym, rd_more, rd_idx} = rdata;

  assign advance      = (rd_sym < c_q) && rd_more;
  assign at_last      = (pos_q == ptl_pkg::LAST_ADDR);
  // advancing past the last entry falls through as a miss
  assign found        = !advance && (rd_sym == c_q);
  assign idx_in_range = 32'(rd_idx) < 32'(ptl_pkg::TABLE_DEPTH);

  always_comb begin
    cur_d        = cur_q;
    missed_d     = missed_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    if (cmd_i.ignore) begin
      res_status_d = ptl_pkg::ST_IGNORED;
      res_index_d  = '0;
      if (in_c == '0) begin
        missed_d = 1'b0;
        cur_d    = '0;
      end
    end else if (cmd_i.resolve) begin
      res_index_d = '0;
      priority if (found && c_q == '0) begin
        res_status_d = ptl_pkg::ST_FOUND;
        res_index_d  = rd_idx;
        cur_d        = '0;
      end else if (found && idx_in_range) begin
        res_status_d = ptl_pkg::ST_PENDING;
        cur_d        = ptl_pkg::ADDR_W'(rd_idx);
      end else begin
        res_status_d = ptl_pkg::ST_MISS;
        cur_d        = '0;
        missed_d     = (c_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      missed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      missed_q <= missed_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    if (cmd_i.start) begin
      c_q   <= in_c;
      pos_q <= cur_q;
    end else if (cmd_i.step) begin
      pos_q <= pos_q + ptl_pkg::ADDR_W'(1);
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign dp_status_o.is_char   = kind_i;
  assign dp_status_o.missed    = missed_q;
  assign dp_status_o.scan_more = advance && !at_last;
  assign dp_status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;

endmodule

>>> rtl/core/packed_trie_lookup.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: top level
// Table load and character-by-character trie walk with one result per char.
// ----------------------------------------------------------------------------
// A load word writes one table entry and leaves the controller idle. A char
// word is accepted, then the sibling scan examines one table entry per cycle
// (the single read port of the table sets this), then the result is handed
// to the output register once that register is free; a char ignored after a
// miss goes from acceptance straight to the hand-off. The output
// register holds one finished word, so a new word is accepted while the
// previous result still waits downstream. The table has no reset value;
// entries must be loaded before a walk reaches them.
module packed_trie_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [11:0] entry_addr_i,
  input  logic [15:0] entry_symbol_i,
  input  logic        entry_more_i,
  input  logic [15:0] entry_index_i,
  input  logic [15:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_index_o
);

`include "packed_trie_lookup_defines.svh"

  ptl_pkg::ctrl_cmd_t  cmd;
  ptl_pkg::dp_status_t dp_status;

  ptl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  ptl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .dp_status_o    (dp_status),
    .kind_i         (kind_i),
    .entry_addr_i   (entry_addr_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_more_i   (entry_more_i),
    .entry_index_i  (entry_index_i),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_index_o (result_index_o)
  );

  // a char word always keeps the block busy once it is accepted
  `PTL_ASSERT_NEXT(a_char_busy, clk_i, rst_ni, in_valid_i && in_ready_o && kind_i, !in_ready_o)
  // index is only non-zero on a hit
  `PTL_ASSERT_SAME(a_idx_on_hit, clk_i, rst_ni, out_valid_o && status_o != ptl_pkg::ST_FOUND, result_index_o == 16'd0)
  // a result never appears straight after a load word
  `PTL_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, in_valid_i && in_ready_o && !kind_i && !out_valid_o, !out_valid_o)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Packed trie lookup: testbench
// Builds random dictionaries into the trie table, walks names through them
// with random sender gaps and receiver stalls, and checks every result word
// against a shadow of the table and of the walk state.
// ----------------------------------------------------------------------------
module testbench;

  localparam bit          KIND_LOAD   = 1'b0;
  localparam bit          KIND_CHAR   = 1'b1;
  localparam int unsigned MAX_WORDS   = 16;
  localparam int unsigned MAX_LEN     = 8;
  localparam int unsigned MAX_NODES   = 160;
  localparam int unsigned MAX_KIDS    = 32;
  localparam int unsigned N_ITEMS     = 1100;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned MAX_REPORTS = 30;
  localparam bit [15:0]   UPPER_A     = 16'h0041;
  localparam bit [15:0]   UPPER_Z     = 16'h005A;
  localparam bit [15:0]   UPPER_F     = 16'h0046;
  localparam bit [15:0]   CASE_GAP    = 16'h0020;
  localparam bit [15:0]   NAME_END    = 16'h0000;

  typedef enum int unsigned {NAME_EXACT, NAME_ALTERED, NAME_CUT, NAME_LONGER} name_form_e;

  typedef struct packed {
    logic [1:0]                status;
    logic [ptl_pkg::IDX_W-1:0] index;
  } walk_result_t;

  // Shadow of the table and the walk; holds the result words still owed.
  class trie_shadow;
    bit [ptl_pkg::SYM_W-1:0] sym_tab [ptl_pkg::TABLE_DEPTH];
    bit                      more_tab[ptl_pkg::TABLE_DEPTH];
    bit [ptl_pkg::IDX_W-1:0] idx_tab [ptl_pkg::TABLE_DEPTH];
    bit                      loaded  [ptl_pkg::TABLE_DEPTH];
    int unsigned    cur_node;
    bit             missed;
    walk_result_t   walk_results_q[$];
    int unsigned    errors;
    int unsigned    n_loads;
    int unsigned    n_chars;
    int unsigned    status_seen[4];

    function bit [ptl_pkg::SYM_W-1:0] fold_case(bit [15:0] code);
      bit [ptl_pkg::SYM_W-1:0] c;
      c = code & ptl_pkg::CHAR_MASK;
      if (c >= 16'h0061 && c <= 16'h007A) c -= CASE_GAP;
      return c;
    endfunction

    // Sibling scan from the current node; returns 0 if it read an unloaded entry.
    function bit scan_list(bit [ptl_pkg::SYM_W-1:0] c, output int unsigned pos,
                           output bit found);
      bit clean;
      bit done;
      clean = 1'b1;
      done  = 1'b0;
      found = 1'b0;
      pos   = cur_node;
      while (!done) begin
        if (!loaded[pos]) clean = 1'b0;
        if (sym_tab[pos] < c && more_tab[pos]) begin
          pos++;
          done = (pos >= ptl_pkg::TABLE_DEPTH);
        end else begin
          found = (sym_tab[pos] == c);
          done  = 1'b1;
        end
      end
      return clean;
    endfunction

    // A char is fit to send if neither the scan nor the next node touches an unloaded entry
    function bit char_safe(bit [15:0] code);
      bit [ptl_pkg::SYM_W-1:0] c;
      int unsigned    pos;
      bit             found;
      if (missed) return 1'b1;
      c = fold_case(code);
      if (!scan_list(c, pos, found)) return 1'b0;
      return !(found && c != 0 && idx_tab[pos] < ptl_pkg::TABLE_DEPTH &&
               !loaded[idx_tab[pos]]);
    endfunction

    function void take_word(bit kind, bit [ptl_pkg::ADDR_W-1:0] addr,
                            bit [ptl_pkg::SYM_W-1:0] sym, bit more,
                            bit [ptl_pkg::IDX_W-1:0] idx, bit [15:0] code);
      walk_result_t   r;
      bit [ptl_pkg::SYM_W-1:0] c;
      int unsigned    pos;
      bit             found;
      if (kind == KIND_LOAD) begin
        n_loads++;
        if (addr < ptl_pkg::TABLE_DEPTH) begin
          sym_tab[addr]  = sym;
          more_tab[addr] = more;
          idx_tab[addr]  = idx;
          loaded[addr]   = 1'b1;
        end
        return;
      end
      n_chars++;
      c = fold_case(code);
      r.index = '0;
      if (missed) begin
        r.status = ptl_pkg::ST_IGNORED;
        if (c == 0) begin
          missed   = 1'b0;
          cur_node = 0;
        end
      end else begin
        void'(scan_list(c, pos, found));
        if (found && c == 0) begin
          r.status = ptl_pkg::ST_FOUND;
          r.index  = idx_tab[pos];
          cur_node = 0;
        end else if (found && idx_tab[pos] < ptl_pkg::TABLE_DEPTH) begin
          r.status = ptl_pkg::ST_PENDING;
          cur_node = idx_tab[pos];
        end else begin
          r.status = ptl_pkg::ST_MISS;
          cur_node = 0;
          missed   = (c != 0);
        end
      end
      status_seen[r.status]++;
      walk_results_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task match_result(logic [1:0] status, logic [ptl_pkg::IDX_W-1:0] index);
      walk_result_t want;
      if (walk_results_q.size() == 0) begin
        report($sformatf("result word with none owed: status %0d index %0h", status, index));
        return;
      end
      want = walk_results_q.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (index !== want.index)
        report($sformatf("result_index %0h, want %0h", index, want.index));
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        kind_i         = KIND_LOAD;
  logic [11:0] entry_addr_i   = '0;
  logic [15:0] entry_symbol_i = '0;
  logic        entry_more_i   = 1'b0;
  logic [15:0] entry_index_i  = '0;
  logic [15:0] char_code_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] result_index_o;

  trie_shadow  shadow = new();
  int unsigned items_sent;
  int unsigned in_idle_pct  = 30;
  int unsigned out_idle_pct = 30;
  bit          hold_request;
  bit [15:0]   top_sym = UPPER_Z;

  // dictionary of the current phase and its trie before packing
  bit [15:0]   word_sym [MAX_WORDS][MAX_LEN];
  int unsigned word_len [MAX_WORDS];
  int unsigned n_words;
  bit [15:0]   kid_sym  [MAX_NODES][MAX_KIDS];
  bit [15:0]   kid_val  [MAX_NODES][MAX_KIDS]; // child node, or stored index for the end mark
  int unsigned kid_cnt  [MAX_NODES];
  int unsigned node_base[MAX_NODES];
  int unsigned n_nodes;

  localparam bit [15:0] PROBE_CHARS [16] = '{
    16'h0000, // hit at the root, largest index
    16'h0061, // lower-case a folds to A, moves to the last entry
    16'h007A, // z folds to Z, scan runs off the end of the table
    16'h0071, // ignored while missed
    16'h0000, // end mark while missed
    16'h0042, // child index beyond the table
    16'h0000,
    16'hFFFF, // largest symbol, deepest root scan
    16'h0000, // hit in the child
    16'h0043, // stops on a larger symbol: miss
    16'h0000,
    16'h0061,
    16'h0000, // end mark not present in the node: miss, not missed
    16'h0060, // just below the fold range
    16'h007B, // just above it, ignored
    16'h0000
  };

  packed_trie_lookup DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .entry_addr_i   (entry_addr_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_more_i   (entry_more_i),
    .entry_index_i  (entry_index_i),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_index_o (result_index_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) shadow.match_result(status_o, result_index_o);
  end

  function automatic int unsigned draw_gap(int unsigned pct);
    return ($urandom_range(99) < pct) ? $urandom_range(18, 1) : 0;
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 10;
      2:       return 40;
      default: return 90;
    endcase
  endfunction

  function automatic bit [15:0] pick_symbol(bit [15:0] top);
    if ($urandom_range(19) == 0) return 16'($urandom_range(16'hFFFF, 16'h0080));
    return 16'($urandom_range(top, UPPER_A));
  endfunction

  // valid stays up across back-to-back words; it drops only when a gap is drawn
  task automatic send_item(bit kind, bit [11:0] addr, bit [15:0] sym, bit more,
                           bit [15:0] idx, bit [15:0] code);
    int unsigned gap;
    gap = draw_gap(in_idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    entry_addr_i   <= addr;
    entry_symbol_i <= sym;
    entry_more_i   <= more;
    entry_index_i  <= idx;
    char_code_i    <= code;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.take_word(kind, addr, sym, more, idx, code);
    items_sent++;
  endtask

  task automatic send_load(bit [11:0] addr, bit [15:0] sym, bit more, bit [15:0] idx);
    send_item(KIND_LOAD, addr, sym, more, idx, 16'($urandom));
  endtask

  task automatic send_char(bit [15:0] code);
    send_item(KIND_CHAR, 12'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), code);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.walk_results_q.size() != 0);
  endtask

  // Random words into a trie with ascending sibling lists, then packed and loaded:
  // root at address 0, the other nodes in one block at a random base.
  task automatic build_dictionary(int unsigned words, int unsigned max_len);
    int unsigned cur, pos, k, rest, addr;
    bit [15:0]   ch;
    n_words    = words;
    n_nodes    = 1;
    kid_cnt[0] = 0;
    for (int w = 0; w < words; w++) begin
      word_len[w] = ($urandom_range(15) == 0) ? 0 : $urandom_range(max_len, 1);
      cur = 0;
      for (int i = 0; i <= word_len[w]; i++) begin
        if (i < word_len[w]) begin
          ch = pick_symbol(top_sym);
          word_sym[w][i] = ch;
        end else begin
          ch = NAME_END;
        end
        pos = 0;
        while (pos < kid_cnt[cur] && kid_sym[cur][pos] < ch) pos++;
        if (pos < kid_cnt[cur] && kid_sym[cur][pos] == ch) begin
          if (ch != NAME_END) cur = kid_val[cur][pos];
        end else begin
          for (k = kid_cnt[cur]; k > pos; k--) begin
            kid_sym[cur][k] = kid_sym[cur][k-1];
            kid_val[cur][k] = kid_val[cur][k-1];
          end
          kid_cnt[cur]++;
          kid_sym[cur][pos] = ch;
          if (ch == NAME_END) begin
            kid_val[cur][pos] = 16'($urandom);
          end else begin
            kid_val[cur][pos] = 16'(n_nodes);
            kid_cnt[n_nodes]  = 0;
            cur = n_nodes;
            n_nodes++;
          end
        end
      end
    end
    rest = 0;
    for (int n = 1; n < n_nodes; n++) rest += kid_cnt[n];
    node_base[0] = 0;
    addr = $urandom_range(ptl_pkg::TABLE_DEPTH - 2 - rest, kid_cnt[0]);
    for (int n = 1; n < n_nodes; n++) begin
      node_base[n] = addr;
      addr += kid_cnt[n];
    end
    for (int n = 0; n < n_nodes; n++) begin
      for (k = 0; k < kid_cnt[n]; k++) begin
        send_load(12'(node_base[n] + k), kid_sym[n][k], k + 1 < kid_cnt[n],
                  (kid_sym[n][k] == NAME_END) ? kid_val[n][k]
                                              : 16'(node_base[kid_val[n][k]]));
      end
    end
  endtask

  task automatic send_name(int unsigned w, name_form_e form);
    bit [15:0] name[$];
    bit [15:0] code;
    for (int i = 0; i < word_len[w]; i++) name.push_back(word_sym[w][i]);
    case (form)
      NAME_ALTERED:
        if (name.size() > 0) name[$urandom_range(name.size() - 1)] = pick_symbol(top_sym);
      NAME_CUT:
        if (name.size() > 0) void'(name.pop_back());
      NAME_LONGER:
        repeat ($urandom_range(3, 1)) name.push_back(pick_symbol(top_sym));
      default: ;
    endcase
    foreach (name[i]) begin
      code = name[i];
      if (code >= UPPER_A && code <= UPPER_Z && $urandom_range(1)) code += CASE_GAP;
      if (!shadow.char_safe(code)) break;
      send_char(code);
    end
    send_char(NAME_END);
  endtask

  task automatic send_noise();
    bit [15:0] code;
    repeat ($urandom_range(6, 1)) begin
      code = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16'h007F, 16'h0020));
      if (shadow.char_safe(code)) send_char(code);
    end
    if ($urandom_range(1)) send_char(NAME_END);
  endtask

  // Overwrite a loaded entry; more is set only where the next entry is loaded
  // too or it is the last entry, so no scan can reach an entry that was never written.
  task automatic send_noise_load();
    bit [11:0] addr;
    bit        more;
    do addr = 12'($urandom); while (!shadow.loaded[addr]);
    more = (addr == ptl_pkg::LAST_ADDR || shadow.loaded[addr + 1]) ? 1'($urandom) : 1'b0;
    send_load(addr, $urandom_range(1) ? 16'($urandom) : pick_symbol(UPPER_Z), more,
              $urandom_range(1) ? 16'($urandom)
                                : 16'($urandom_range(ptl_pkg::TABLE_DEPTH - 1)));
  endtask

  task automatic run_phase(int unsigned phase);
    in_idle_pct  = pick_pct();
    out_idle_pct = pick_pct();
    top_sym      = $urandom_range(1) ? UPPER_F : UPPER_Z;
    build_dictionary($urandom_range(MAX_WORDS, 4), $urandom_range(MAX_LEN, 2));
    if (phase == 1) begin
      in_idle_pct  = 0;
      hold_request = 1'b1;
    end
    if (phase == 2) drain();
    repeat ($urandom_range(40, 20)) begin
      case ($urandom_range(19))
        0, 1:    send_noise();
        2:       send_noise_load();
        3:       send_name($urandom_range(n_words - 1), NAME_ALTERED);
        4:       send_name($urandom_range(n_words - 1), NAME_CUT);
        5:       send_name($urandom_range(n_words - 1), NAME_LONGER);
        default: send_name($urandom_range(n_words - 1), NAME_EXACT);
      endcase
    end
    send_char(NAME_END);
  endtask

  initial begin : receiver
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stall = draw_gap(out_idle_pct);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_load(12'd0, 16'h0000, 1'b1, 16'hFFFF);
    send_load(12'd1, UPPER_A, 1'b1, 16'(ptl_pkg::TABLE_DEPTH - 1));
    send_load(12'd2, 16'h0042, 1'b1, 16'(ptl_pkg::TABLE_DEPTH));
    send_load(12'd3, 16'hFFFF, 1'b0, 16'd5);
    send_load(12'd5, 16'h0000, 1'b0, 16'h1234);
    send_load(ptl_pkg::LAST_ADDR, 16'h0001, 1'b1, 16'h0000);
    foreach (PROBE_CHARS[i]) send_char(PROBE_CHARS[i]);

    phase = 0;
    while (items_sent < N_ITEMS) begin
      run_phase(phase);
      phase++;
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Run: %0d words over %0d dictionaries (%0d table loads, %0d chars)",
             items_sent, phase, shadow.n_loads, shadow.n_chars);
    $display("Results: %0d pending, %0d found, %0d not found, %0d ignored",
             shadow.status_seen[ptl_pkg::ST_PENDING], shadow.status_seen[ptl_pkg::ST_FOUND],
             shadow.status_seen[ptl_pkg::ST_MISS], shadow.status_seen[ptl_pkg::ST_IGNORED]);
    if (shadow.errors == 0 && shadow.walk_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ptl_pkg.sv
rtl/core/ptl_ram.sv
rtl/core/ptl_ctrl.sv
rtl/core/ptl_dp.sv
rtl/core/packed_trie_lookup.sv
sim/testbench.sv
